// File: sv/sphpvf_pkg.sv
`timescale 1ns / 1ps

package sphpvf_pkg;

    // Fixed data word of every Q-format field
    localparam int Q_W = 32;

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    // Register reset values
    localparam logic [30:0]        H_RST    = 31'd65536;
    localparam logic signed [31:0] COEF_RST = -32'sd936;
    localparam logic [30:0]        KC_RST   = 31'd936;
    localparam logic [30:0]        MU_RST   = 31'd65536;

    // Register indexes
    localparam logic [1:0] REG_H    = 2'd0;
    localparam logic [1:0] REG_COEF = 2'd1;
    localparam logic [1:0] REG_KC   = 2'd2;
    localparam logic [1:0] REG_MU   = 2'd3;

    // Divide / square-root unit control and status
    typedef struct packed {
        logic start;
        logic sqrt;
    } t_ds_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ds_stat;

    // Magnitude of a signed word, 2^31 included
    function automatic logic [31:0] mag32(input logic signed [31:0] a);
        mag32 = a[31] ? 32'(-a) : 32'(a);
    endfunction

    // Apply sign to a magnitude, saturate to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
        logic signed [31:0] res;
        if (neg) begin
            res = (mag >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
        end else begin
            res = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
        end
        sat32 = res;
    endfunction

endpackage

// File: sv/sphpvf_divsqrt.sv
`timescale 1ns / 1ps

// Radix-2 restoring divider and bit-pair square root sharing one subtractor
module sphpvf_divsqrt #(
    parameter int FRAC_BITS = sphpvf_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sphpvf_pkg::t_ds_ctrl      i_ctrl,
    input  logic [63:0]               i_rad,
    input  logic [31:0]               i_dvd,
    input  logic [31:0]               i_den,
    output sphpvf_pkg::t_ds_stat      o_stat,
    output logic [32+FRAC_BITS-1:0]   o_quo,
    output logic [31:0]               o_root
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int XW = (DW > 64) ? DW : 64;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic          r_sqrt;
    logic [CW-1:0] r_cnt;
    logic [35:0]   r_rem;
    logic [XW-1:0] r_x;
    logic [31:0]   r_root;
    logic [31:0]   r_den;

    logic [35:0] w_rem_sh;
    logic [35:0] w_trial;
    logic [35:0] w_diff;
    logic        w_ge;

    // One step: shift in next dividend bit or radicand bit pair, trial subtract
    always_comb begin
        if (r_sqrt) begin
            w_rem_sh = {r_rem[33:0], r_x[XW-1 -: 2]};
            w_trial  = {2'b00, r_root, 2'b01};
        end else begin
            w_rem_sh = {r_rem[34:0], r_x[XW-1]};
            w_trial  = {4'b0000, r_den};
        end
        w_ge   = (w_rem_sh >= w_trial);
        w_diff = w_rem_sh - w_trial;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctrl.sqrt ? CW'(32) : CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_sqrt <= i_ctrl.sqrt;
            r_rem  <= '0;
            r_root <= '0;
            r_den  <= i_den;
            if (i_ctrl.sqrt) begin
                r_x <= XW'(i_rad) << (XW - 64);
            end else begin
                r_x <= XW'({i_dvd, {FRAC_BITS{1'b0}}}) << (XW - DW);
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_rem_sh;
            if (r_sqrt) begin
                r_x    <= r_x << 2;
                r_root <= {r_root[30:0], w_ge};
            end else begin
                r_x <= {r_x[XW-2:0], w_ge};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_x[DW-1:0];
    assign o_root      = r_root;

endmodule

// File: sv/sph_pressure_viscosity_force.sv
`timescale 1ns / 1ps

// SPH pressure and viscosity force accumulator for one particle. Neighbour pairs
// arrive one item at a time on the slave stream; tlast marks the final pair, and
// that item produces one result item with the saturated pressure and viscous force
// vectors, after which the sums clear. One pair is processed at a time through a
// single 32x32 multiplier and one iterative divide/square-root unit that retires
// one bit per cycle. A pair with zero density goes straight to the final step,
// and a pair outside the support radius takes only the square root. Coincident
// particles take the square root and one division. A full pair takes the square
// root (32 steps) and the three divisions (32+FRAC_BITS steps each). A last pair
// also waits while the previous result item is still held on the master stream.
// Registers are to be written over the APB-style port only while idle; the block
// itself does not enforce it.
module sph_pressure_viscosity_force #(
    parameter int FRAC_BITS = sphpvf_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = sphpvf_pkg::ACC_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // APB-style configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // Pair input
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // offset_x, offset_y, offset_z, vel_diff_x, vel_diff_y, vel_diff_z (32 each),
    // own_pressure, neighbour_pressure, neighbour_density (31 each), 3 zero bits
    input  logic [287:0]  s_axis_tdata,
    input  logic          s_axis_tlast,   // last_pair
    // Force output
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // pressure_force_x, _y, _z, viscous_force_x, _y, _z (32 each)
    output logic [191:0]  m_axis_tdata
);

    localparam int DW = 32 + FRAC_BITS;

    // Sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_R2   = 5'd1;
    localparam logic [4:0] S_CHK  = 5'd2;
    localparam logic [4:0] S_P1   = 5'd3;
    localparam logic [4:0] S_P2   = 5'd4;
    localparam logic [4:0] S_P3   = 5'd5;
    localparam logic [4:0] S_P4   = 5'd6;
    localparam logic [4:0] S_P5   = 5'd7;
    localparam logic [4:0] S_P6   = 5'd8;
    localparam logic [4:0] S_P7   = 5'd9;
    localparam logic [4:0] S_P8   = 5'd10;
    localparam logic [4:0] S_V1   = 5'd11;
    localparam logic [4:0] S_V2   = 5'd12;
    localparam logic [4:0] S_V3   = 5'd13;
    localparam logic [4:0] S_V4   = 5'd14;
    localparam logic [4:0] S_V5   = 5'd15;
    localparam logic [4:0] S_V6   = 5'd16;
    localparam logic [4:0] S_DSGO = 5'd17;
    localparam logic [4:0] S_DSW  = 5'd18;
    localparam logic [4:0] S_FIN  = 5'd19;

    // Configuration
    logic [30:0]        r_h;
    logic signed [31:0] r_coef;
    logic [30:0]        r_kc;
    logic [30:0]        r_mu;

    // Latched pair
    logic signed [31:0] r_off [3];
    logic signed [31:0] r_vel [3];
    logic [30:0]        r_half;
    logic [30:0]        r_dj;
    logic               r_last;

    // Working registers
    logic [4:0]         r_state;
    logic [4:0]         r_ret;
    logic [1:0]         r_k;
    logic               r_op;
    logic [63:0]        r_r2;
    logic [31:0]        r_r;
    logic signed [31:0] r_d;
    logic signed [31:0] r_t;
    logic signed [31:0] r_s;
    logic signed [31:0] r_f;
    logic signed [31:0] r_w;
    logic signed [31:0] r_da;
    logic [31:0]        r_db;

    logic signed [ACC_WIDTH-1:0] r_psum [3];
    logic signed [ACC_WIDTH-1:0] r_vsum [3];

    logic               r_ovalid;
    logic [191:0]       r_odata;

    logic                  w_cfg_wr;
    logic                  w_accept;
    logic signed [31:0]    w_ma;
    logic signed [31:0]    w_mb;
    logic [63:0]           w_prod;
    logic signed [31:0]    w_qmul;
    sphpvf_pkg::t_ds_ctrl  w_ds_ctrl;
    sphpvf_pkg::t_ds_stat  w_ds_stat;
    logic [DW-1:0]         w_quo;
    logic [31:0]           w_root;
    logic signed [32:0]    w_c;
    logic signed [ACC_WIDTH-1:0] w_acc_in;
    logic signed [ACC_WIDTH:0]   w_acc_sum;
    logic signed [ACC_WIDTH-1:0] w_acc_new;
    logic [191:0]          w_odata;

    // APB
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h    <= sphpvf_pkg::H_RST;
            r_coef <= sphpvf_pkg::COEF_RST;
            r_kc   <= sphpvf_pkg::KC_RST;
            r_mu   <= sphpvf_pkg::MU_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                sphpvf_pkg::REG_H:    r_h    <= pwdata[30:0];
                sphpvf_pkg::REG_COEF: r_coef <= $signed(pwdata);
                sphpvf_pkg::REG_KC:   r_kc   <= pwdata[30:0];
                sphpvf_pkg::REG_MU:   r_mu   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sphpvf_pkg::REG_H:    prdata = {1'b0, r_h};
            sphpvf_pkg::REG_COEF: prdata = r_coef;
            sphpvf_pkg::REG_KC:   prdata = {1'b0, r_kc};
            sphpvf_pkg::REG_MU:   prdata = {1'b0, r_mu};
            default:              prdata = '0;
        endcase
    end

    // Shared multiplier: operand select, magnitude product, Q shift and saturate
    always_comb begin
        case (r_state)
            S_R2:    begin w_ma = r_off[r_k];   w_mb = r_off[r_k];   end
            S_P1:    begin w_ma = r_d;          w_mb = r_d;          end
            S_P2:    begin w_ma = r_coef;       w_mb = r_t;          end
            S_P6:    begin w_ma = r_off[r_k];   w_mb = r_s;          end
            S_P7:    begin w_ma = r_t;          w_mb = r_f;          end
            S_V1:    begin w_ma = {1'b0, r_kc}; w_mb = r_d;          end
            S_V2:    begin w_ma = r_t;          w_mb = {1'b0, r_mu}; end
            S_V5:    begin w_ma = r_vel[r_k];   w_mb = r_w;          end
            default: begin w_ma = '0;           w_mb = '0;           end
        endcase
        w_prod = sphpvf_pkg::mag32(w_ma) * sphpvf_pkg::mag32(w_mb);
        w_qmul = sphpvf_pkg::sat32(w_ma[31] ^ w_mb[31], w_prod >> FRAC_BITS);
    end

    // Divide / square-root unit
    assign w_ds_ctrl.start = (r_state == S_DSGO);
    assign w_ds_ctrl.sqrt  = r_op;

    sphpvf_divsqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ds_ctrl),
        .i_rad   (r_r2),
        .i_dvd   (sphpvf_pkg::mag32(r_da)),
        .i_den   (r_db),
        .o_stat  (w_ds_stat),
        .o_quo   (w_quo),
        .o_root  (w_root)
    );

    // Saturating accumulate: pressure adds the negated term
    always_comb begin
        if (r_state == S_P8) begin
            w_c      = -33'(r_t);
            w_acc_in = r_psum[r_k];
        end else begin
            w_c      = 33'(r_t);
            w_acc_in = r_vsum[r_k];
        end
        w_acc_sum = (ACC_WIDTH+1)'(w_acc_in) + (ACC_WIDTH+1)'(w_c);
        if (w_acc_sum[ACC_WIDTH] != w_acc_sum[ACC_WIDTH-1]) begin
            w_acc_new = w_acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                             : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            w_acc_new = w_acc_sum[ACC_WIDTH-1:0];
        end
    end

    // Output saturation of the sums to 32 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_psum[i][ACC_WIDTH-1:31] == '0 || r_psum[i][ACC_WIDTH-1:31] == '1) begin
                w_odata[32*i +: 32] = r_psum[i][31:0];
            end else begin
                w_odata[32*i +: 32] = r_psum[i][ACC_WIDTH-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            if (r_vsum[i][ACC_WIDTH-1:31] == '0 || r_vsum[i][ACC_WIDTH-1:31] == '1) begin
                w_odata[96+32*i +: 32] = r_vsum[i][31:0];
            end else begin
                w_odata[96+32*i +: 32] = r_vsum[i][ACC_WIDTH-1] ? 32'h8000_0000
                                                                 : 32'h7FFF_FFFF;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_k      <= '0;
            r_op     <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_psum[i] <= '0;
                r_vsum[i] <= '0;
            end
        end else begin
            // Result valid: load on a last pair, drop once taken
            if (r_state == S_FIN && r_last && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_k     <= '0;
                        r_state <= (s_axis_tdata[284:254] == '0) ? S_FIN : S_R2;
                    end
                end
                S_R2: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        r_op    <= 1'b1;
                        r_ret   <= S_CHK;
                        r_state <= S_DSGO;
                    end
                end
                S_CHK: begin
                    if (r_r > {1'b0, r_h}) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= (r_r != '0) ? S_P1 : S_V1;
                    end
                end
                S_P1: r_state <= S_P2;
                S_P2: r_state <= S_P3;
                S_P3: begin
                    r_op    <= 1'b0;
                    r_ret   <= S_P4;
                    r_state <= S_DSGO;
                end
                S_P4: begin
                    r_ret   <= S_P5;
                    r_state <= S_DSGO;
                end
                S_P5: begin
                    r_k     <= '0;
                    r_state <= S_P6;
                end
                S_P6: r_state <= S_P7;
                S_P7: r_state <= S_P8;
                S_P8: begin
                    r_psum[r_k] <= w_acc_new;
                    r_k         <= r_k + 1'b1;
                    r_state     <= (r_k == 2'd2) ? S_V1 : S_P6;
                end
                S_V1: r_state <= S_V2;
                S_V2: r_state <= S_V3;
                S_V3: begin
                    r_op    <= 1'b0;
                    r_ret   <= S_V4;
                    r_state <= S_DSGO;
                end
                S_V4: begin
                    r_k     <= '0;
                    r_state <= S_V5;
                end
                S_V5: r_state <= S_V6;
                S_V6: begin
                    r_vsum[r_k] <= w_acc_new;
                    r_k         <= r_k + 1'b1;
                    r_state     <= (r_k == 2'd2) ? S_FIN : S_V5;
                end
                S_DSGO: r_state <= S_DSW;
                S_DSW: begin
                    if (w_ds_stat.done) begin
                        r_state <= r_ret;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (!r_ovalid || m_axis_tready) begin
                        for (int i = 0; i < 3; i++) begin
                            r_psum[i] <= '0;
                            r_vsum[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    for (int i = 0; i < 3; i++) begin
                        r_off[i] <= $signed(s_axis_tdata[32*i +: 32]);
                        r_vel[i] <= $signed(s_axis_tdata[96+32*i +: 32]);
                    end
                    r_half <= 31'((32'(s_axis_tdata[222:192]) + 32'(s_axis_tdata[253:223])) >> 1);
                    r_dj   <= s_axis_tdata[284:254];
                    r_last <= s_axis_tlast;
                    r_r2   <= '0;
                end
            end
            S_R2:  r_r2 <= r_r2 + w_prod;
            S_CHK: r_d  <= $signed(32'(r_h) - r_r);
            S_P1, S_P2, S_P6, S_P7, S_V1, S_V2, S_V5: r_t <= w_qmul;
            S_P3: begin
                r_da <= r_t;
                r_db <= r_r;
            end
            S_P4: begin
                r_s  <= r_t;
                r_da <= $signed({1'b0, r_half});
                r_db <= {1'b0, r_dj};
            end
            S_P5: r_f <= r_t;
            S_V3: begin
                r_da <= r_t;
                r_db <= {1'b0, r_dj};
            end
            S_V4: r_w <= r_t;
            S_DSW: begin
                if (w_ds_stat.done) begin
                    if (r_op) begin
                        r_r <= w_root;
                    end else begin
                        r_t <= sphpvf_pkg::sat32(r_da[31], 64'(w_quo));
                    end
                end
            end
            S_FIN: begin
                if (r_last && (!r_ovalid || m_axis_tready)) begin
                    r_odata <= w_odata;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Checks
    a_ds_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ds_ctrl.start |-> !w_ds_stat.busy)
        else $error("divide/root unit started while busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("ready held after an accepted item");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_FIN) && $past(r_last))
        else $error("result raised outside the final step");

    a_lane_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P8 || r_state == S_V6 || r_state == S_R2) |-> r_k != 2'd3)
        else $error("axis index out of range");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ds_stat.done |-> r_state == S_DSW)
        else $error("divide/root result arrived while not waiting");

endmodule

// File: tb/sph_force_checker.sv
`timescale 1ns / 1ps

module sph_force_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [191:0] m_axis_tdata,
    output int           o_errors,
    output int           o_pending
);

    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

    logic [30:0]        h_q;
    logic signed [31:0] coef_q;
    logic [30:0]        kc_q;
    logic [30:0]        mu_q;
    logic signed [47:0] psum [3];
    logic signed [47:0] vsum [3];
    logic [191:0]       force_q [$];
    int                 err_cnt = 0;
    int                 pend_cnt = 0;

    assign o_errors  = err_cnt;
    assign o_pending = pend_cnt;

    function automatic longint clamp32(bit neg, longint unsigned m);
        if (neg) return (m >= 64'h8000_0000) ? -64'sh8000_0000 : -longint'(m);
        return (m > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(m);
    endfunction

    // Q product, magnitude truncated, saturated to 32 bits
    function automatic longint qmul(longint a, longint b);
        longint unsigned p;
        p = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> 16;
        return clamp32((a < 0) != (b < 0), p);
    endfunction

    function automatic longint qdiv(longint a, longint unsigned b);
        longint unsigned q;
        q = ((a < 0 ? -a : a) << 16) / b;
        return clamp32(a < 0, q);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [47:0] acc_add(logic signed [47:0] acc, longint c);
        longint s;
        s = longint'(acc) + c;
        if (s > longint'(ACC_MAX)) return ACC_MAX;
        if (s < longint'(ACC_MIN)) return ACC_MIN;
        return 48'(s);
    endfunction

    function automatic logic [31:0] out32(logic signed [47:0] v);
        if (v > 48'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -48'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Accumulate one neighbour pair, queue the forces on the last pair
    task automatic add_pair(input logic [287:0] d, input logic last);
        longint off [3];
        longint vel [3];
        longint unsigned pi, pj, dj, r2, r, dd;
        longint s, f, lap, w, c;
        logic [191:0] res;
        for (int k = 0; k < 3; k++) begin
            off[k] = longint'($signed(d[32*k +: 32]));
            vel[k] = longint'($signed(d[96 + 32*k +: 32]));
        end
        pi = d[192 +: 31];
        pj = d[223 +: 31];
        dj = d[254 +: 31];
        if (dj != 0) begin
            r2 = 0;
            for (int k = 0; k < 3; k++) begin
                dd = off[k] < 0 ? -off[k] : off[k];
                r2 += dd * dd;
            end
            r = floor_root(r2);
            if (r <= h_q) begin
                dd = h_q - r;
                if (r > 0) begin
                    s = qdiv(qmul(coef_q, qmul(dd, dd)), r);
                    f = qdiv(longint'((pi + pj) >> 1), dj);
                    for (int k = 0; k < 3; k++) begin
                        c = qmul(qmul(off[k], s), f);
                        psum[k] = acc_add(psum[k], -c);
                    end
                end
                lap = qmul(longint'(kc_q), dd);
                w = qdiv(qmul(lap, longint'(mu_q)), dj);
                for (int k = 0; k < 3; k++)
                    vsum[k] = acc_add(vsum[k], qmul(vel[k], w));
            end
        end
        if (last) begin
            for (int k = 0; k < 3; k++) begin
                res[32*k +: 32] = out32(psum[k]);
                res[96 + 32*k +: 32] = out32(vsum[k]);
                psum[k] = '0;
                vsum[k] = '0;
            end
            force_q = {force_q, res};
        end
    endtask

    always @(posedge i_clk) begin
        logic [191:0] want;
        if (!i_rst_n) begin
            h_q <= sphpvf_pkg::H_RST;
            coef_q <= sphpvf_pkg::COEF_RST;
            kc_q <= sphpvf_pkg::KC_RST;
            mu_q <= sphpvf_pkg::MU_RST;
            for (int k = 0; k < 3; k++) begin
                psum[k] = '0;
                vsum[k] = '0;
            end
            err_cnt = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    sphpvf_pkg::REG_H:    h_q <= pwdata[30:0];
                    sphpvf_pkg::REG_COEF: coef_q <= pwdata;
                    sphpvf_pkg::REG_KC:   kc_q <= pwdata[30:0];
                    sphpvf_pkg::REG_MU:   mu_q <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                add_pair(s_axis_tdata, s_axis_tlast);
            // compare result item against oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                if (force_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("unexpected force item %h", m_axis_tdata);
                    err_cnt = err_cnt + 1;
                end else begin
                    want = force_q.pop_front();
                    for (int k = 0; k < 6; k++) begin
                        if (want[32*k +: 32] !== m_axis_tdata[32*k +: 32]) begin
                            if (err_cnt < 10)
                                $display("force field %0d: expected %h, got %h",
                                         k, want[32*k +: 32], m_axis_tdata[32*k +: 32]);
                            err_cnt = err_cnt + 1;
                        end
                    end
                end
            end
        end
        pend_cnt = force_q.size();
    end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 20000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 0, s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [191:0] m_axis_tdata;
    int           errors, pending;
    int           idle_cycles = 0;
    bit           no_gaps = 0;
    bit           hold_off = 0;

    always #2 i_clk = ~i_clk;

    sph_pressure_viscosity_force i_dut (.*);

    sph_force_checker i_chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver: random stalls, one long hold-off
    always @(posedge i_clk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_gaps || ($urandom_range(99) >= 19);
        end
    end

    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1;
        repeat (3000) @(posedge i_clk);
        hold_off = 0;
    end

    // Watchdog on cycles without any accepted item or APB select
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    // Hold the item until an edge with ready high; ready is sampled mid-cycle
    task automatic send_pair(input logic [287:0] d, input logic last);
        bit taken;
        while (!no_gaps && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        s_axis_tlast <= last;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic logic [287:0] pack_pair(logic [31:0] ox, oy, oz, vx, vy, vz,
                                               logic [30:0] pi, pj, dj);
        return {3'b0, dj, pj, pi, vz, vy, vx, oz, oy, ox};
    endfunction

    // Offset component sized around h so pairs land inside and outside support
    function automatic logic [31:0] rnd_off(int unsigned hv);
        int unsigned m;
        case ($urandom_range(9))
            0: return $urandom;
            1: return '0;
            default: begin
                m = $urandom_range(hv / 2 + 1);
                return $urandom_range(1) ? -m : m;
            end
        endcase
    endfunction

    function automatic logic [30:0] rnd31();
        case ($urandom_range(5))
            0: return 31'h7FFF_FFFF;
            1: return 31'($urandom);
            default: return 31'($urandom_range(32'h0004_0000));
        endcase
    endfunction

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int unsigned hv);
        logic [30:0] dj;
        for (int i = 0; i < n; i++) begin
            dj = ($urandom_range(19) == 0) ? 31'd0 : rnd31();
            if (dj == 0 && $urandom_range(1)) dj = 31'd1;
            send_pair(pack_pair(rnd_off(hv), rnd_off(hv), rnd_off(hv),
                                $urandom, $urandom, $urandom, rnd31(), rnd31(), dj),
                      $urandom_range(5) == 0);
        end
        send_pair(pack_pair('0, '0, '0, '0, '0, '0, '0, '0, '0), 1);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes and special cases with reset registers
        no_gaps = 1;
        send_pair(pack_pair(32'h4000, 32'h2000, 32'h1000, 32'h10000, -32'h10000, 32'h7FFFFFFF,
                            31'h10000, 31'h20000, 31'h10000), 1);
        send_pair(pack_pair('0, '0, '0, 32'h80000000, 32'h7FFFFFFF, 32'h1,
                            31'h7FFFFFFF, 31'h7FFFFFFF, 31'h1), 0);   // coincident
        send_pair(pack_pair(32'h8000, '0, '0, 32'h1234, '0, '0, 31'h100, 31'h200, 31'h0), 1);
        send_pair(pack_pair(32'h20000, '0, '0, 32'h5000, '0, '0, 31'h100, 31'h200,
                            31'h10000), 1);
        send_pair(pack_pair(32'h80000000, 32'h80000000, 32'h80000000, '0, '0, '0,
                            31'h1, 31'h1, 31'h7FFFFFFF), 1);
        send_pair(pack_pair(32'hFFFFFFFF, 32'h1, 32'hFFFF0000, 32'hFFFFFFFF, 32'h1, 32'h0,
                            31'h7FFFFFFF, 31'h0, 31'h1), 1);
        // saturation: tiny density, big pressures
        for (int i = 0; i < 6; i++)
            send_pair(pack_pair(32'h100, -32'h100, 32'h80, 32'h7FFFFFFF, 32'h80000000,
                                32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h1), i == 5);
        no_gaps = 0;
        drain();

        // register extremes and typical settings
        reg_write(sphpvf_pkg::REG_H, 32'h7FFF_FFFF);
        reg_write(sphpvf_pkg::REG_COEF, 32'h8000_0000);
        reg_write(sphpvf_pkg::REG_KC, 32'h7FFF_FFFF);
        reg_write(sphpvf_pkg::REG_MU, 32'h7FFF_FFFF);
        random_phase(150, 32'h7FFF_FFFF);
        drain();

        reg_write(sphpvf_pkg::REG_H, 32'h0);
        reg_write(sphpvf_pkg::REG_COEF, 32'h0);
        reg_write(sphpvf_pkg::REG_KC, 32'h0);
        reg_write(sphpvf_pkg::REG_MU, 32'h0);
        random_phase(100, 4);
        drain();

        reg_write(sphpvf_pkg::REG_H, 32'h0002_0000);
        reg_write(sphpvf_pkg::REG_COEF, -32'd3000);
        reg_write(sphpvf_pkg::REG_KC, 32'd3000);
        reg_write(sphpvf_pkg::REG_MU, 32'h0000_8000);
        no_gaps = 1;
        random_phase(250, 32'h0002_0000);
        no_gaps = 0;
        random_phase(250, 32'h0002_0000);
        drain();

        reg_write(sphpvf_pkg::REG_H, $urandom);
        reg_write(sphpvf_pkg::REG_COEF, -$urandom_range(32'h7FFF_FFFF));
        reg_write(sphpvf_pkg::REG_KC, $urandom);
        reg_write(sphpvf_pkg::REG_MU, $urandom);
        random_phase(250, 32'h0010_0000);
        drain();

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
